>>> rtl/core/spq_pkg.sv
// shared constants and types for the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

   localparam int CAPACITY_DEF  = 16;
   localparam int PRIO_BITS_DEF = 8;
   localparam int DATA_BITS_DEF = 32;

   typedef enum logic [1:0] {
      REQ_PEEK   = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type op;
   } cell_ctrl_type;

endpackage

>>> rtl/core/spq_cell.sv
// one compare-and-shift cell of the sorted chain
`timescale 1ns / 1ps

module spq_cell #(
   parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
   parameter int DATA_BITS = spq_pkg::DATA_BITS_DEF
) (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                  occupied,
   input  logic [PRIO_BITS-1:0]  new_prio,
   input  logic [DATA_BITS-1:0]  new_data,
   input  logic                  prev_keep,
   input  logic [PRIO_BITS-1:0]  prev_prio,
   input  logic [DATA_BITS-1:0]  prev_data,
   input  logic [PRIO_BITS-1:0]  next_prio,
   input  logic [DATA_BITS-1:0]  next_data,
   output logic                  keep,
   output logic [PRIO_BITS-1:0]  prio,
   output logic [DATA_BITS-1:0]  data
);

   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic [DATA_BITS-1:0] data_ff, data_in;

   // a held entry of greater or equal priority stays ahead of the new one
   assign keep = occupied && (prio_ff >= new_prio);

   always_comb begin
      prio_in = prio_ff;
      data_in = data_ff;
      case (ctrl.op)
         spq_pkg::CELL_INSERT: begin
            if (keep) begin
               prio_in = prio_ff;
               data_in = data_ff;
            end else if (prev_keep) begin
               prio_in = new_prio;
               data_in = new_data;
            end else begin
               prio_in = prev_prio;
               data_in = prev_data;
            end
         end
         spq_pkg::CELL_REMOVE: begin
            prio_in = next_prio;
            data_in = next_data;
         end
         default: begin
            prio_in = prio_ff;
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      data_ff <= data_in;
   end

   assign prio = prio_ff;
   assign data = data_ff;

endmodule

>>> rtl/core/sorted_priority_queue_top.sv
// Sorted priority queue: bounded, highest priority first, ties in arrival order.
// Requests arrive on the req_ channel (valid/ready) as peek, insert, remove
// head or clear; each accepted transaction yields exactly one response on the
// rsp_ channel holding the head entry, valid flag, count, full flag and a flag
// for an insert refused because the queue was full.
// Entries live in a row of CAPACITY compare-and-shift cells; an insert or a
// removal moves every cell in the same cycle.
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one transaction per cycle while rsp_ready is high; the single
// response register is freed and refilled in the same cycle.
// When the receiver stalls, the response holds and req_ready drops until the
// response is taken; no request is lost or reordered.
// Reset (synchronous, active high) empties the queue and drops any pending
// response; cell contents are not cleared, only the entry count.
`timescale 1ns / 1ps

module sorted_priority_queue_top #(
   parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
   parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
   parameter int DATA_BITS = spq_pkg::DATA_BITS_DEF,
   localparam int CNT_BITS = $clog2(CAPACITY + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  logic [PRIO_BITS-1:0] req_entry_prio,
   input  logic [DATA_BITS-1:0] req_entry_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_head_valid,
   output logic [PRIO_BITS-1:0] rsp_head_prio,
   output logic [DATA_BITS-1:0] rsp_head_data,
   output logic [CNT_BITS-1:0]  rsp_entry_count,
   output logic                 rsp_queue_full,
   output logic                 rsp_insert_dropped
);

   logic                rsp_valid_ff, rsp_valid_in;
   logic                dropped_ff, dropped_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                accept;
   logic                full;
   logic                empty;
   spq_pkg::req_code_type req_code;
   spq_pkg::cell_ctrl_type ctrl;

   logic [PRIO_BITS-1:0] cell_prio [CAPACITY];
   logic [DATA_BITS-1:0] cell_data [CAPACITY];
   logic                 cell_keep [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_BITS'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign req_code  = spq_pkg::req_code_type'(req_type);

   always_comb begin
      ctrl.op    = spq_pkg::CELL_HOLD;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (accept) begin
         dropped_in = 1'b0;
         case (req_code)
            spq_pkg::REQ_INSERT: begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  ctrl.op  = spq_pkg::CELL_INSERT;
                  count_in = count_ff + CNT_BITS'(1);
               end
            end
            spq_pkg::REQ_REMOVE: begin
               if (!empty) begin
                  ctrl.op  = spq_pkg::CELL_REMOVE;
                  count_in = count_ff - CNT_BITS'(1);
               end
            end
            spq_pkg::REQ_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                 prev_keep;
      logic [PRIO_BITS-1:0] prev_prio;
      logic [DATA_BITS-1:0] prev_data;
      logic [PRIO_BITS-1:0] next_prio;
      logic [DATA_BITS-1:0] next_data;
      logic                 occupied;

      assign occupied = (CNT_BITS'(i) < count_ff);

      if (i == 0) begin : g_first
         // the head has no predecessor, so a new entry never comes from the left
         assign prev_keep = 1'b1;
         assign prev_prio = req_entry_prio;
         assign prev_data = req_entry_data;
      end else begin : g_inner
         assign prev_keep = cell_keep[i-1];
         assign prev_prio = cell_prio[i-1];
         assign prev_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_prio = cell_prio[i];
         assign next_data = cell_data[i];
      end else begin : g_body
         assign next_prio = cell_prio[i+1];
         assign next_data = cell_data[i+1];
      end

      spq_cell #(
         .PRIO_BITS (PRIO_BITS),
         .DATA_BITS (DATA_BITS)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occupied),
         .new_prio  (req_entry_prio),
         .new_data  (req_entry_data),
         .prev_keep (prev_keep),
         .prev_prio (prev_prio),
         .prev_data (prev_data),
         .next_prio (next_prio),
         .next_data (next_data),
         .keep      (cell_keep[i]),
         .prio      (cell_prio[i]),
         .data      (cell_data[i])
      );
   end

   // the cells and count only move on acceptance, so they match the pending response
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_head_valid     = !empty;
   assign rsp_head_prio      = empty ? '0 : cell_prio[0];
   assign rsp_head_data      = empty ? '0 : cell_data[0];
   assign rsp_entry_count    = count_ff;
   assign rsp_queue_full     = full;
   assign rsp_insert_dropped = dropped_ff;

endmodule

>>> dv/sorted_priority_queue_top_test.sv
// self-checking testbench for the sorted priority queue top level
`timescale 1ns / 1ps

module sorted_priority_queue_top_test;

   localparam int DEPTH      = spq_pkg::CAPACITY_DEF;
   localparam int QUIET_MAX  = 1000;

   typedef struct {
      logic        head_valid;
      logic [7:0]  head_prio;
      logic [31:0] head_data;
      logic [4:0]  entry_count;
      logic        queue_full;
      logic        insert_dropped;
   } head_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = spq_pkg::REQ_PEEK;
   logic [7:0]  req_entry_prio = '0;
   logic [31:0] req_entry_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_head_valid;
   logic [7:0]  rsp_head_prio;
   logic [31:0] rsp_head_data;
   logic [4:0]  rsp_entry_count;
   logic        rsp_queue_full;
   logic        rsp_insert_dropped;

   // predictor state: sorted copy of the queue contents
   logic [7:0]      model_prio [DEPTH];
   logic [31:0]     model_data [DEPTH];
   int              model_count = 0;
   head_report_type pending_reports [$];

   int  errors = 0;
   int  quiet_cycles = 0;
   bit  req_idle_on = 1'b0;
   bit  rsp_idle_on = 1'b0;
   bit  allow_idle = 1'b1;

   sorted_priority_queue_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_entry_prio     (req_entry_prio),
      .req_entry_data     (req_entry_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_head_valid     (rsp_head_valid),
      .rsp_head_prio      (rsp_head_prio),
      .rsp_head_data      (rsp_head_data),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_queue_full     (rsp_queue_full),
      .rsp_insert_dropped (rsp_insert_dropped)
   );

   always #5 clock = ~clock;

   function automatic head_report_type update_queue_model(spq_pkg::req_code_type kind,
                                                          logic [7:0] prio,
                                                          logic [31:0] data);
      head_report_type rep;
      int pos;
      rep.insert_dropped = 1'b0;
      case (kind)
         spq_pkg::REQ_INSERT: begin
            if (model_count >= DEPTH) begin
               rep.insert_dropped = 1'b1;
            end else begin
               // new entry goes behind everything of equal or higher priority
               pos = 0;
               while (pos < model_count && model_prio[pos] >= prio) pos++;
               for (int i = model_count; i > pos; i--) begin
                  model_prio[i] = model_prio[i-1];
                  model_data[i] = model_data[i-1];
               end
               model_prio[pos] = prio;
               model_data[pos] = data;
               model_count++;
            end
         end
         spq_pkg::REQ_REMOVE: begin
            if (model_count > 0) begin
               for (int i = 0; i + 1 < model_count; i++) begin
                  model_prio[i] = model_prio[i+1];
                  model_data[i] = model_data[i+1];
               end
               model_count--;
            end
         end
         spq_pkg::REQ_CLEAR: model_count = 0;
         default: ;
      endcase
      rep.head_valid  = (model_count > 0);
      rep.head_prio   = (model_count > 0) ? model_prio[0] : 8'd0;
      rep.head_data   = (model_count > 0) ? model_data[0] : 32'd0;
      rep.entry_count = model_count[4:0];
      rep.queue_full  = (model_count == DEPTH);
      return rep;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   // response checking and prediction of every accepted request transaction
   always @(posedge clock) begin
      head_report_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               errors++;
               $display("%0t: response with nothing expected, expected none actual count %0d",
                        $time, rsp_entry_count);
            end else begin
               want = pending_reports.pop_front();
               check_field("head_valid", 32'(want.head_valid), 32'(rsp_head_valid));
               check_field("head_prio", 32'(want.head_prio), 32'(rsp_head_prio));
               check_field("head_data", want.head_data, rsp_head_data);
               check_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
               check_field("queue_full", 32'(want.queue_full), 32'(rsp_queue_full));
               check_field("insert_dropped", 32'(want.insert_dropped),
                           32'(rsp_insert_dropped));
            end
         end
         if (req_valid && req_ready)
            pending_reports.push_back(update_queue_model(spq_pkg::req_code_type'(req_type),
                                                         req_entry_prio, req_entry_data));
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver side: ready with random stall bursts
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_request(spq_pkg::req_code_type kind, logic [7:0] prio,
                               logic [31:0] data);
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_entry_prio <= prio;
      req_entry_data <= data;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   task automatic run_random(int n, int ins_w, int rem_w, int clr_w, int prio_lo, int prio_hi);
      int r;
      spq_pkg::req_code_type kind;
      for (int i = 0; i < n; i++) begin
         if (i % 32 == 0) begin
            req_idle_on = allow_idle && $urandom_range(0, 2) != 0;
            rsp_idle_on = allow_idle && $urandom_range(0, 2) != 0;
         end
         r = $urandom_range(0, 99);
         if (r < ins_w) kind = spq_pkg::REQ_INSERT;
         else if (r < ins_w + rem_w) kind = spq_pkg::REQ_REMOVE;
         else if (r < ins_w + rem_w + clr_w) kind = spq_pkg::REQ_CLEAR;
         else kind = spq_pkg::REQ_PEEK;
         send_request(kind, 8'($urandom_range(prio_lo, prio_hi)), $urandom());
      end
   endtask

   task automatic test_empty_queue();
      send_request(spq_pkg::REQ_PEEK, 8'hFF, 32'hFFFF_FFFF);
      send_request(spq_pkg::REQ_REMOVE, 8'h00, 32'h0000_0000);
      send_request(spq_pkg::REQ_CLEAR, 8'hA5, 32'h5A5A_A5A5);
   endtask

   task automatic test_fill_overflow();
      logic [7:0] prios [DEPTH] = '{8'd0, 8'd255, 8'd128, 8'd128, 8'd255, 8'd0, 8'd64, 8'd200,
                                    8'd128, 8'd1, 8'd254, 8'd64, 8'd7, 8'd255, 8'd0, 8'd128};
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0) send_request(spq_pkg::REQ_INSERT, prios[i], 32'h0000_0000);
         else if (i == 1) send_request(spq_pkg::REQ_INSERT, prios[i], 32'hFFFF_FFFF);
         else send_request(spq_pkg::REQ_INSERT, prios[i], {8'(i), 8'hC3, 8'(~i), 8'h3C});
      end
      // full: even the highest priority is refused
      send_request(spq_pkg::REQ_INSERT, 8'd255, 32'hDEAD_0001);
      send_request(spq_pkg::REQ_PEEK, 8'd0, 32'd0);
   endtask

   task automatic test_clear_full();
      send_request(spq_pkg::REQ_CLEAR, 8'd0, 32'd0);
      send_request(spq_pkg::REQ_INSERT, 8'd17, 32'h1234_5678);
      send_request(spq_pkg::REQ_REMOVE, 8'd0, 32'd0);
   endtask

   task automatic test_fill_heavy();
      run_random(150, 60, 25, 2, 0, 255);
   endtask

   task automatic test_equal_priorities();
      run_random(150, 50, 40, 2, 100, 103);
   endtask

   task automatic test_balanced_mix();
      run_random(150, 45, 45, 3, 0, 255);
   endtask

   task automatic test_pause_until_drained();
      run_random(25, 70, 20, 0, 0, 15);
      wait_drained();
      run_random(25, 30, 60, 0, 0, 15);
   endtask

   task automatic test_steady_no_idle();
      allow_idle  = 1'b0;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_random(150, 50, 45, 1, 0, 255);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      test_empty_queue();
      test_fill_overflow();
      test_clear_full();
      test_fill_heavy();
      test_equal_priorities();
      test_balanced_mix();
      test_pause_until_drained();
      test_steady_no_idle();
      wait_drained();
      repeat (5) @(posedge clock);
      if (errors == 0 && pending_reports.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
